// ===== rtl/core/diff_drive_speed_conditioner_assert.svh =====
`ifndef DIFF_DRIVE_SPEED_CONDITIONER_ASSERT_SVH
`define DIFF_DRIVE_SPEED_CONDITIONER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DDSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define DDSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ddsc_pkg.sv =====
package ddsc_pkg;

	localparam int VEL_W    = 13;
	localparam int OMEGA_W  = 14;
	localparam int TRACK_W  = 11;
	localparam int SBOUND_W = 13;
	localparam int UBOUND_W = 12;
	localparam int GAIN_W   = 16;
	localparam int CMD_W    = 13;

	// speeds are held at 1/2000 mm/s
	localparam int SPEED_W = 27;
	localparam int TURN_W  = 26;
	localparam int MAG_W   = 23;
	localparam int PROD_W  = 39;
	localparam int DEN_SH  = 17;
	localparam int QUOT_W  = PROD_W - DEN_SH;
	localparam int EST_W   = 35;
	localparam int RECIP_SH = 22;

	localparam logic signed [SPEED_W-1:0] SCALE_MM = 27'sd2000;
	localparam logic [PROD_W-1:0] HALF_DEN = 39'd65536000;
	localparam logic [12:0] RECIP_M = 13'd4194;
	localparam int DIVISOR = 1000;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_TRACK,
		REG_DEAD_LOW,
		REG_DEAD_HIGH,
		REG_HYST_LOW,
		REG_HYST_HIGH,
		REG_LIMIT_LOW,
		REG_LIMIT_HIGH,
		REG_GAIN
	} reg_idx_t;

	localparam logic [TRACK_W-1:0]  RST_TRACK      = 11'd255;
	localparam logic [SBOUND_W-1:0] RST_DEAD_LOW   = 13'h1DDA;
	localparam logic [UBOUND_W-1:0] RST_DEAD_HIGH  = 12'd550;
	localparam logic [SBOUND_W-1:0] RST_HYST_LOW   = 13'h1C90;
	localparam logic [UBOUND_W-1:0] RST_HYST_HIGH  = 12'd880;
	localparam logic [SBOUND_W-1:0] RST_LIMIT_LOW  = 13'h1AD8;
	localparam logic [UBOUND_W-1:0] RST_LIMIT_HIGH = 12'd1320;
	localparam logic [GAIN_W-1:0]   RST_GAIN       = 16'd7266;

	typedef struct packed {
		logic [TRACK_W-1:0]  wheel_track_mm;
		logic [SBOUND_W-1:0] dead_low;
		logic [UBOUND_W-1:0] dead_high;
		logic [SBOUND_W-1:0] hyst_low;
		logic [UBOUND_W-1:0] hyst_high;
		logic [SBOUND_W-1:0] limit_low;
		logic [UBOUND_W-1:0] limit_high;
		logic [GAIN_W-1:0]   speed_gain;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic mix;
		logic cond;
		logic kick_phase;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic kick_any;
	} dp_status_t;

	function automatic logic signed [SPEED_W-1:0] scale_mm(input logic signed [13:0] x);
		logic signed [SPEED_W-1:0] xe;
		xe = SPEED_W'(x);
		return xe * SCALE_MM;
	endfunction

endpackage

// ===== rtl/core/ddsc_regs.sv =====
module ddsc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ddsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ddsc_pkg::DATA_W-1:0]   pwdata,
	output logic [ddsc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output ddsc_pkg::cfg_t                cfg
);

	ddsc_pkg::cfg_t     cfg_q;
	ddsc_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = ddsc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_track_mm <= ddsc_pkg::RST_TRACK;
			cfg_q.dead_low       <= ddsc_pkg::RST_DEAD_LOW;
			cfg_q.dead_high      <= ddsc_pkg::RST_DEAD_HIGH;
			cfg_q.hyst_low       <= ddsc_pkg::RST_HYST_LOW;
			cfg_q.hyst_high      <= ddsc_pkg::RST_HYST_HIGH;
			cfg_q.limit_low      <= ddsc_pkg::RST_LIMIT_LOW;
			cfg_q.limit_high     <= ddsc_pkg::RST_LIMIT_HIGH;
			cfg_q.speed_gain     <= ddsc_pkg::RST_GAIN;
		end else if (wr_en) begin
			unique case (idx)
				ddsc_pkg::REG_TRACK:      cfg_q.wheel_track_mm <= pwdata[ddsc_pkg::TRACK_W-1:0];
				ddsc_pkg::REG_DEAD_LOW:   cfg_q.dead_low       <= pwdata[ddsc_pkg::SBOUND_W-1:0];
				ddsc_pkg::REG_DEAD_HIGH:  cfg_q.dead_high      <= pwdata[ddsc_pkg::UBOUND_W-1:0];
				ddsc_pkg::REG_HYST_LOW:   cfg_q.hyst_low       <= pwdata[ddsc_pkg::SBOUND_W-1:0];
				ddsc_pkg::REG_HYST_HIGH:  cfg_q.hyst_high      <= pwdata[ddsc_pkg::UBOUND_W-1:0];
				ddsc_pkg::REG_LIMIT_LOW:  cfg_q.limit_low      <= pwdata[ddsc_pkg::SBOUND_W-1:0];
				ddsc_pkg::REG_LIMIT_HIGH: cfg_q.limit_high     <= pwdata[ddsc_pkg::UBOUND_W-1:0];
				ddsc_pkg::REG_GAIN:       cfg_q.speed_gain     <= pwdata[ddsc_pkg::GAIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ddsc_pkg::REG_TRACK:      prdata = ddsc_pkg::DATA_W'(cfg_q.wheel_track_mm);
			ddsc_pkg::REG_DEAD_LOW:   prdata = ddsc_pkg::DATA_W'(cfg_q.dead_low);
			ddsc_pkg::REG_DEAD_HIGH:  prdata = ddsc_pkg::DATA_W'(cfg_q.dead_high);
			ddsc_pkg::REG_HYST_LOW:   prdata = ddsc_pkg::DATA_W'(cfg_q.hyst_low);
			ddsc_pkg::REG_HYST_HIGH:  prdata = ddsc_pkg::DATA_W'(cfg_q.hyst_high);
			ddsc_pkg::REG_LIMIT_LOW:  prdata = ddsc_pkg::DATA_W'(cfg_q.limit_low);
			ddsc_pkg::REG_LIMIT_HIGH: prdata = ddsc_pkg::DATA_W'(cfg_q.limit_high);
			ddsc_pkg::REG_GAIN:       prdata = ddsc_pkg::DATA_W'(cfg_q.speed_gain);
		endcase
	end

endmodule

// ===== rtl/core/ddsc_scale.sv =====
module ddsc_scale (
	input  logic                                  clk,
	input  logic signed [ddsc_pkg::SPEED_W-1:0]   speed,
	input  logic signed [ddsc_pkg::SPEED_W-1:0]   limit_hi,
	input  logic signed [ddsc_pkg::SPEED_W-1:0]   limit_lo,
	input  logic [ddsc_pkg::GAIN_W-1:0]           gain,
	output logic signed [ddsc_pkg::CMD_W-1:0]     command
);

	logic signed [ddsc_pkg::SPEED_W-1:0] c_hi, c_lim;
	logic [ddsc_pkg::MAG_W-1:0]          mag;
	logic [ddsc_pkg::PROD_W-1:0]         prod;
	logic [ddsc_pkg::EST_W-1:0]          est;
	logic [ddsc_pkg::QUOT_W:0]           rem;
	logic [ddsc_pkg::CMD_W-1:0]          q;

	logic [ddsc_pkg::MAG_W-1:0]  mag_s1;
	logic                        neg_s1;
	logic [ddsc_pkg::QUOT_W-1:0] t_s2;
	logic                        neg_s2;
	logic [ddsc_pkg::QUOT_W-1:0] t_s3;
	logic [ddsc_pkg::CMD_W-1:0]  q0_s3;
	logic                        neg_s3;

	// clamp, low limit wins when limits cross
	always_comb begin
		c_hi  = (speed > limit_hi) ? limit_hi : speed;
		c_lim = (c_hi < limit_lo) ? limit_lo : c_hi;
		mag   = ddsc_pkg::MAG_W'(c_lim[ddsc_pkg::SPEED_W-1] ? -c_lim : c_lim);
	end

	// magnitude times gain plus half the divisor, divided by 2^17
	assign prod = ddsc_pkg::PROD_W'(mag_s1) * ddsc_pkg::PROD_W'(gain) + ddsc_pkg::HALF_DEN;

	// reciprocal estimate of t / 1000, low by at most one
	assign est = ddsc_pkg::EST_W'(t_s2) * ddsc_pkg::EST_W'(ddsc_pkg::RECIP_M);

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		neg_s1 <= c_lim[ddsc_pkg::SPEED_W-1];
		t_s2   <= prod[ddsc_pkg::PROD_W-1:ddsc_pkg::DEN_SH];
		neg_s2 <= neg_s1;
		t_s3   <= t_s2;
		q0_s3  <= est[ddsc_pkg::RECIP_SH +: ddsc_pkg::CMD_W];
		neg_s3 <= neg_s2;
	end

	always_comb begin
		rem = {1'b0, t_s3} - (ddsc_pkg::QUOT_W+1)'(q0_s3) * (ddsc_pkg::QUOT_W+1)'(ddsc_pkg::DIVISOR);
		q   = q0_s3 + ddsc_pkg::CMD_W'(rem >= (ddsc_pkg::QUOT_W+1)'(ddsc_pkg::DIVISOR));
		command = neg_s3 ? $signed(-q) : $signed(q);
	end

endmodule

// ===== rtl/core/ddsc_datapath.sv =====
module ddsc_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ddsc_pkg::cfg_t                        cfg,
	input  ddsc_pkg::dp_cmd_t                     cmd,
	output ddsc_pkg::dp_status_t                  status,
	input  logic signed [ddsc_pkg::VEL_W-1:0]     linear_velocity,
	input  logic signed [ddsc_pkg::OMEGA_W-1:0]   angular_velocity,
	output logic signed [ddsc_pkg::CMD_W-1:0]     left_command,
	output logic signed [ddsc_pkg::CMD_W-1:0]     right_command,
	output logic                                  is_kick,
	output logic                                  last
);

	localparam int SW = ddsc_pkg::SPEED_W;

	logic signed [ddsc_pkg::VEL_W-1:0]   v_q;
	logic signed [ddsc_pkg::OMEGA_W-1:0] w_q;
	logic signed [ddsc_pkg::TURN_W-1:0]  turn_q;
	logic signed [SW-1:0]                base_q;
	logic                                spin_q;
	logic signed [SW-1:0]                left_q, right_q;
	logic                                kick_l_q, kick_r_q;
	logic                                left_zero_q, right_zero_q;
	logic signed [ddsc_pkg::CMD_W-1:0]   left_cmd_q, right_cmd_q;
	logic                                is_kick_q, last_q;

	logic signed [SW-1:0] dl, dh, hl, hh, lo, hi;
	logic signed [SW-1:0] left_raw, right_raw, left_c, right_c;
	logic signed [SW-1:0] left_sel, right_sel;
	logic                 dead_l, dead_r, kick_l, kick_r;
	logic signed [ddsc_pkg::CMD_W-1:0] l_cmd, r_cmd;

	always_comb begin
		dl = ddsc_pkg::scale_mm(14'($signed(cfg.dead_low)));
		dh = ddsc_pkg::scale_mm($signed({2'b00, cfg.dead_high}));
		hl = ddsc_pkg::scale_mm(14'($signed(cfg.hyst_low)));
		hh = ddsc_pkg::scale_mm($signed({2'b00, cfg.hyst_high}));
		lo = ddsc_pkg::scale_mm(14'($signed(cfg.limit_low)));
		hi = ddsc_pkg::scale_mm($signed({2'b00, cfg.limit_high}));
	end

	always_comb begin
		left_raw  = spin_q ? base_q : base_q - SW'(turn_q);
		right_raw = spin_q ? -base_q : base_q + SW'(turn_q);
		dead_l    = (dl < left_raw) && (left_raw < dh);
		dead_r    = (dl < right_raw) && (right_raw < dh);
		left_c    = dead_l ? '0 : left_raw;
		right_c   = dead_r ? '0 : right_raw;
		kick_l    = !dead_l && (hl < left_raw) && (left_raw < hh) && left_zero_q;
		kick_r    = !dead_r && (hl < right_raw) && (right_raw < hh) && right_zero_q;
	end

	// kicked wheel goes to the limit of its sign
	always_comb begin
		left_sel  = left_q;
		right_sel = right_q;
		if (cmd.kick_phase && kick_l_q) begin
			left_sel = (left_q > 0) ? hi : lo;
		end
		if (cmd.kick_phase && kick_r_q) begin
			right_sel = (right_q > 0) ? hi : lo;
		end
	end

	ddsc_scale u_scale_left (
		.clk      (clk),
		.speed    (left_sel),
		.limit_hi (hi),
		.limit_lo (lo),
		.gain     (cfg.speed_gain),
		.command  (l_cmd)
	);

	ddsc_scale u_scale_right (
		.clk      (clk),
		.speed    (right_sel),
		.limit_hi (hi),
		.limit_lo (lo),
		.gain     (cfg.speed_gain),
		.command  (r_cmd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q <= linear_velocity;
			w_q <= angular_velocity;
		end
		if (cmd.mix) begin
			turn_q <= ddsc_pkg::TURN_W'(w_q) *
				ddsc_pkg::TURN_W'($signed({1'b0, cfg.wheel_track_mm}));
			base_q <= (v_q != 0) ? SW'(v_q) * ddsc_pkg::SCALE_MM
				: SW'(w_q) * ddsc_pkg::SCALE_MM;
			spin_q <= (v_q == 0);
		end
		if (cmd.cond) begin
			left_q   <= left_c;
			right_q  <= right_c;
			kick_l_q <= kick_l;
			kick_r_q <= kick_r;
		end
		if (cmd.load_out) begin
			left_cmd_q  <= l_cmd;
			right_cmd_q <= r_cmd;
			is_kick_q   <= cmd.kick_phase;
			last_q      <= !cmd.kick_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_zero_q  <= 1'b1;
			right_zero_q <= 1'b1;
		end else if (cmd.cond) begin
			left_zero_q  <= (left_c == 0);
			right_zero_q <= (right_c == 0);
		end
	end

	assign status.kick_any = kick_l_q || kick_r_q;
	assign left_command    = left_cmd_q;
	assign right_command   = right_cmd_q;
	assign is_kick         = is_kick_q;
	assign last            = last_q;

endmodule

// ===== rtl/core/ddsc_ctrl.sv =====
`include "diff_drive_speed_conditioner_assert.svh"

module ddsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ddsc_pkg::dp_cmd_t    cmd,
	input  ddsc_pkg::dp_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX,
		ST_COND,
		ST_SEL,
		ST_ISSUE,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   kick_phase_q;
	logic   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kick_phase_q <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX:   state_q <= ST_COND;
				ST_COND:  state_q <= ST_SEL;
				ST_SEL: begin
					kick_phase_q <= status.kick_any;
					state_q      <= ST_ISSUE;
				end
				ST_ISSUE: state_q <= ST_P1;
				ST_P1:    state_q <= ST_P2;
				ST_P2:    state_q <= ST_P3;
				ST_P3: begin
					valid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						valid_q <= 1'b0;
						if (kick_phase_q) begin
							kick_phase_q <= 1'b0;
							state_q      <= ST_ISSUE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// scaler output settles in the last pipeline state and loads on entering the output state
	always_comb begin
		cmd.load_in    = (state_q == ST_IDLE) && in_valid;
		cmd.mix        = (state_q == ST_MIX);
		cmd.cond       = (state_q == ST_COND);
		cmd.kick_phase = kick_phase_q;
		cmd.load_out   = (state_q == ST_P3);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = valid_q;

	`DDSC_ASSERT_NOW(a_busy_while_result, valid_q, in_stall, "input taken while a result is pending")
	`DDSC_ASSERT_NEXT(a_kick_then_normal, valid_q && !out_stall && kick_phase_q, (state_q == ST_ISSUE) && !kick_phase_q, "normal result does not follow kick")
	`DDSC_ASSERT_NOW(a_valid_after_scale, $rose(valid_q), $past(state_q) == ST_P3, "result raised without scaler pass")

endmodule

// ===== rtl/core/diff_drive_speed_conditioner.sv =====
// Differential-drive wheel speed conditioner. Each input transaction carries a linear velocity
// (mm/s) and a turn rate (mrad/s); the block mixes them into left and right wheel speeds, zeroes
// speeds inside the dead zone, clamps them to the limits and scales them by the gain with
// rounding half away from zero. When a wheel that was stopped lands inside the start-kick zone,
// a kick transaction (is_kick high, last low) with that wheel at its limit comes out before the
// normal one (last high). One input is handled at a time: after acceptance the block runs
// the mix, condition and select steps, then the scaler pipeline (gain multiply, reciprocal
// multiply, correction) once per result, and takes no new input until the last result has
// left the output. Configuration registers are written through the APB port at byte address
// 4*index; the user must write them only while the block is idle, which the block itself
// does not enforce.
module diff_drive_speed_conditioner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ddsc_pkg::ADDR_W-1:0]           paddr,
	input  logic [ddsc_pkg::DATA_W-1:0]           pwdata,
	output logic [ddsc_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ddsc_pkg::VEL_W-1:0]     linear_velocity,
	input  logic signed [ddsc_pkg::OMEGA_W-1:0]   angular_velocity,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ddsc_pkg::CMD_W-1:0]     left_command,
	output logic signed [ddsc_pkg::CMD_W-1:0]     right_command,
	output logic                                  is_kick,
	output logic                                  last
);

	ddsc_pkg::cfg_t       cfg;
	ddsc_pkg::dp_cmd_t    cmd;
	ddsc_pkg::dp_status_t status;

	ddsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddsc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.status           (status),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.left_command     (left_command),
		.right_command    (right_command),
		.is_kick          (is_kick),
		.last             (last)
	);

	ddsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
